// ===== rtl/pbl_pkg.sv =====
`timescale 1ns / 1ps

package pbl_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} st_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the input transfer
		logic setup;      // compute clamped index and start position
		logic mem_rd;     // read the neighbor (or the target for a read)
		logic shift_wr;   // write the neighbor into the current slot, step
		logic ins_wr;     // write new byte at index, count up
		logic cnt_dec;
		logic cnt_clr;
		logic out_load;
		logic out_sel_rd; // result data from memory, else zero
		st_t  out_status;
	} pbl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic more;       // another shift step is pending
		logic out_free;   // output register can take a result
	} pbl_stat_t;

endpackage

// ===== rtl/pbl_dp.sv =====
`timescale 1ns / 1ps

module pbl_dp #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbl_pkg::pbl_cmd_t cmd,
	output pbl_pkg::pbl_stat_t stat,
	input  logic [1:0]        opcode,
	input  logic [7:0]        position,
	input  logic [7:0]        data_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_out,
	output logic [6:0]        count,
	output logic [1:0]        status
);
	import pbl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 8) ? CW + 1 : 9;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// 1-based position onto 0-based index below limit
	function automatic logic [CW-1:0] clamp_idx(input logic [7:0] pos,
			input logic [PW-1:0] limit);
		logic [PW-1:0] p;
		p = PW'(pos);
		if (p <= PW'(1))
			return '0;
		else if (p > limit)
			return CW'(limit - PW'(1));
		else
			return CW'(p - PW'(1));
	endfunction

	logic [7:0]    mem [CAPACITY];
	logic [7:0]    rdata_s1;

	op_t           op_q;
	logic [7:0]    pos_q;
	logic [7:0]    byte_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] idx_q;

	logic          out_valid_q;
	logic [7:0]    dout_q;
	logic [CW-1:0] cnt_out_q;
	st_t           st_out_q;

	logic [CW-1:0] raddr;
	logic [CW-1:0] waddr;
	logic [7:0]    wdata;
	logic [CW-1:0] idx_new;

	always_comb begin
		if (op_q == OP_INSERT)
			idx_new = clamp_idx(pos_q, PW'(count_q) + PW'(1));
		else
			idx_new = clamp_idx(pos_q, PW'(count_q));
	end

	always_comb begin
		case (op_q)
			OP_INSERT: raddr = k_q - CW'(1);
			OP_REMOVE: raddr = k_q + CW'(1);
			default:   raddr = k_q;
		endcase
	end

	assign waddr = cmd.ins_wr ? idx_q : k_q;
	assign wdata = cmd.ins_wr ? byte_q : rdata_s1;

	always_ff @(posedge clk) begin
		if (cmd.shift_wr || cmd.ins_wr)
			mem[waddr[AW-1:0]] <= wdata;
		if (cmd.mem_rd)
			rdata_s1 <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op_t'(opcode);
			pos_q  <= position;
			byte_q <= data_in;
		end
		if (cmd.setup) begin
			idx_q <= idx_new;
			k_q   <= (op_q == OP_INSERT) ? count_q : idx_new;
		end else if (cmd.shift_wr) begin
			k_q <= (op_q == OP_INSERT) ? k_q - CW'(1) : k_q + CW'(1);
		end
		if (cmd.out_load) begin
			dout_q    <= cmd.out_sel_rd ? rdata_s1 : 8'd0;
			cnt_out_q <= count_q;
			st_out_q  <= cmd.out_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr)
				count_q <= '0;
			else if (cmd.ins_wr)
				count_q <= count_q + CW'(1);
			else if (cmd.cnt_dec)
				count_q <= count_q - CW'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.op       = op_q;
		stat.full     = (count_q == CAP_C);
		stat.empty    = (count_q == '0);
		stat.out_free = !out_valid_q || out_ready;
		if (op_q == OP_INSERT)
			stat.more = (k_q > idx_q);
		else
			stat.more = ((PW'(k_q) + PW'(1)) < PW'(count_q));
	end

	assign out_valid = out_valid_q;
	assign data_out  = dout_q;
	assign count     = 7'(cnt_out_q);
	assign status    = st_out_q;

endmodule

// ===== rtl/pbl_ctrl.sv =====
`timescale 1ns / 1ps

module pbl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pbl_pkg::pbl_stat_t stat,
	output pbl_pkg::pbl_cmd_t  cmd
);
	import pbl_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DISP  = 6'b000010,
		S_LOOP  = 6'b000100,
		S_SHWR  = 6'b001000,
		S_RDMEM = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	st_t    st_q, st_d;
	logic   rd_q, rd_d;

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		rd_d    = rd_q;
		cmd     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					st_d    = ST_OK;
					rd_d    = 1'b0;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							st_d    = ST_FULL;
							state_d = S_DONE;
						end else begin
							cmd.setup = 1'b1;
							state_d   = S_LOOP;
						end
					end
					OP_REMOVE: begin
						if (stat.empty) begin
							st_d    = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							cmd.setup = 1'b1;
							state_d   = S_LOOP;
						end
					end
					OP_READ: begin
						if (stat.empty) begin
							st_d    = ST_EMPTY;
							state_d = S_DONE;
						end else begin
							cmd.setup = 1'b1;
							rd_d      = 1'b1;
							state_d   = S_RDMEM;
						end
					end
					default: begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_DONE;
					end
				endcase
			end
			S_LOOP: begin
				if (stat.more) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_SHWR;
				end else begin
					if (stat.op == OP_INSERT)
						cmd.ins_wr = 1'b1;
					else
						cmd.cnt_dec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_LOOP;
			end
			S_RDMEM: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				cmd.out_sel_rd = rd_q;
				cmd.out_status = st_q;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			rd_q    <= rd_d;
		end
	end

endmodule

// ===== rtl/positional_byte_list.sv =====
`timescale 1ns / 1ps
// Clear, full insert and empty remove/read go from dispatch to the result; OP_READ adds a
// registered memory read; insert and remove step a shift loop, each element moved by a
// registered read then a write, before the final byte write or count update. One operation
// at a time: the next input is taken on return to idle, in the cycle after the result is
// loaded (later while a previous result is still held).
// Reset (arst_n low, asynchronous): list empty, no result pending; memory contents kept.
module positional_byte_list #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] position,
	input  logic [7:0] data_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic [6:0] count,
	output logic [1:0] status
);
	import pbl_pkg::*;

	// Command/status link between sequencer and datapath
	pbl_cmd_t  cmd;
	pbl_stat_t stat;

	// Sequencer: decodes the captured op, walks the shift loop, hands
	// the result to the output register when it is free.
	pbl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: element memory, count, clamp logic, output register.
	// The output register decouples result transfer from the next input.
	pbl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.position  (position),
		.data_in   (data_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.count     (count),
		.status    (status)
	);

endmodule
